// ===== rtl/modular_arithmetic_unit_top_defines.svh =====
// assertion macros for the modular arithmetic unit
`ifndef MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// property that holds outside reset
`define MAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define MAU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/mau_pkg.sv =====
package mau_pkg;

    localparam int unsigned Width = 32;
    localparam int unsigned CntW  = $clog2(Width + 1);

    localparam logic [Width-1:0] ModReset = Width'(32'd1000000007);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4
    } t_opcode;

    // command to the shared reduction unit
    typedef struct packed {
        logic             start;
        logic [2*Width-1:0] x;   // multiplicand (< 2^W) or value to reduce
        logic [Width-1:0] y;     // multiplier; 1 for plain reduction
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic             busy;
        logic [Width-1:0] result;
    } t_mul_rsp;

endpackage

// ===== rtl/mau_if.sv =====
interface mau_in_if;
    import mau_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       opcode;
    logic [Width-1:0] operand_a;
    logic [Width-1:0] operand_b;
    modport source (output valid, opcode, operand_a, operand_b, input ready);
    modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface mau_out_if;
    import mau_pkg::*;
    logic             valid;
    logic             ready;
    logic [Width-1:0] result_value;
    logic             equal_flag;
    modport source (output valid, result_value, equal_flag, input ready);
    modport sink (input valid, result_value, equal_flag, output ready);
endinterface

interface mau_cfg_if;
    import mau_pkg::*;
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/modular_arithmetic_unit_top.sv =====
// channel  dir  payload                           beat when
// in_ch    in   opcode, operand_a, operand_b      valid & ready
// out_ch   out  result_value, equal_flag          valid & ready
// cfg_ch   in   modulus (data)                    valid & ready
// one item at a time. add, sub and compare take two passes of the shared
// multiply/reduce unit (operand reduction); multiply one pass more; divide
// up to 2*W+1 further passes (square-and-multiply).
// reset (synchronous, active low) loads modulus 1000000007 and idles.
// in_ch is not ready until the result beat has been taken on out_ch.
module modular_arithmetic_unit_top
    import mau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mau_in_if.sink    in_ch,
    mau_out_if.source out_ch,
    mau_cfg_if.sink   cfg_ch
);

    logic [Width-1:0] r_modulus;
    logic [Width-1:0] mod_eff;
    t_mul_req         req;
    t_mul_rsp         rsp;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= ModReset;
        end else if (cfg_ch.valid) begin
            r_modulus <= cfg_ch.data;
        end
    end

    // moduli 0 and 1 act as 1
    assign mod_eff = (r_modulus < Width'(2)) ? Width'(1) : r_modulus;

    mau_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mod   (mod_eff),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .o_req   (req),
        .i_rsp   (rsp)
    );

    mau_mulred u_mulred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mod   (mod_eff),
        .i_req   (req),
        .o_rsp   (rsp)
    );

endmodule

// ===== rtl/mau_mulred.sv =====
// shift-and-add modular multiply: x*y mod m, one multiplier bit per cycle,
// x first reduced by restoring shift-subtract over 2W bits
module mau_mulred
    import mau_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [Width-1:0] i_mod,
    input  t_mul_req         i_req,
    output t_mul_rsp         o_rsp
);

    typedef enum logic [1:0] {S_IDLE, S_RED, S_MUL} t_state;

    localparam int unsigned RCntW = $clog2(2*Width + 1);

    t_state             r_state;
    logic [2*Width-1:0] r_x;     // remaining bits of value to reduce
    logic [Width:0]     r_rem;   // partial remainder
    logic [RCntW-1:0]   r_rcnt;
    logic [Width-1:0]   r_y;
    logic [Width-1:0]   r_acc;
    logic [CntW-1:0]    r_mcnt;
    logic               r_done;

    logic [Width:0]   rem_sh;
    logic [Width:0]   acc_dbl;
    logic [Width:0]   acc_add;
    logic [Width-1:0] acc_d;
    logic [Width-1:0] xr;
    logic [Width:0]   mod_e;

    always_comb begin
        mod_e   = {1'b0, i_mod};
        rem_sh  = {r_rem[Width-1:0], r_x[2*Width-1]};
        xr      = r_rem[Width-1:0];
        acc_dbl = {r_acc, 1'b0};
        if (acc_dbl >= mod_e) begin
            acc_dbl = acc_dbl - mod_e;
        end
        acc_d   = acc_dbl[Width-1:0];
        acc_add = {1'b0, acc_d} + {1'b0, xr};
        if (acc_add >= mod_e) begin
            acc_add = acc_add - mod_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= i_req.x;
                        r_y     <= i_req.y;
                        r_rem   <= '0;
                        r_rcnt  <= RCntW'(2*Width);
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_x <= {r_x[2*Width-2:0], 1'b0};
                    if (rem_sh >= mod_e) begin
                        r_rem <= rem_sh - mod_e;
                    end else begin
                        r_rem <= rem_sh;
                    end
                    r_rcnt <= r_rcnt - 1'b1;
                    if (r_rcnt == RCntW'(1)) begin
                        r_acc   <= '0;
                        r_mcnt  <= CntW'(Width);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // msb-first double and add
                    if (r_y[Width-1]) begin
                        r_acc <= acc_add[Width-1:0];
                    end else begin
                        r_acc <= acc_d;
                    end
                    r_y    <= {r_y[Width-2:0], 1'b0};
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == CntW'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.busy   = (r_state != S_IDLE);
    assign o_rsp.result = r_acc;

endmodule

// ===== rtl/mau_seq.sv =====
// operation sequencer: reduces operands, runs add/sub/compare, and
// drives multiply and square-and-multiply through the shared unit
module mau_seq
    import mau_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [Width-1:0] i_mod,
    mau_in_if.sink           in_ch,
    mau_out_if.source        out_ch,
    output t_mul_req         o_req,
    input  t_mul_rsp         i_rsp
);

    `include "modular_arithmetic_unit_top_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_RED_A, S_RED_B, S_EXEC, S_PSQ, S_PMUL, S_FIN, S_OUT
    } t_state;

    t_state           r_state;
    logic             r_wait;
    logic [2:0]       r_op;
    logic [Width-1:0] r_a;
    logic [Width-1:0] r_b;
    logic [Width-1:0] r_base;
    logic [Width-1:0] r_acc;
    logic [Width-1:0] r_exp;
    logic [Width-1:0] r_res;
    logic             r_eq;
    logic             r_valid;
    t_mul_req         r_req;

    logic [Width:0] sum;
    logic [Width:0] mod_e;

    assign mod_e = {1'b0, i_mod};
    assign sum   = {1'b0, r_a} + {1'b0, r_b};

    assign in_ch.ready         = (r_state == S_IDLE);
    assign out_ch.valid        = r_valid;
    assign out_ch.result_value = r_res;
    assign out_ch.equal_flag   = r_eq;
    assign o_req               = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_wait    <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_op        <= in_ch.opcode;
                        r_b         <= in_ch.operand_b;
                        r_req.start <= 1'b1;
                        r_req.x     <= {{Width{1'b0}}, in_ch.operand_a};
                        r_req.y     <= Width'(1);
                        r_wait      <= 1'b1;
                        r_state     <= S_RED_A;
                    end
                end
                S_RED_A: begin
                    if (i_rsp.done) begin
                        r_a         <= i_rsp.result;
                        r_req.start <= 1'b1;
                        r_req.x     <= {{Width{1'b0}}, r_b};
                        r_req.y     <= Width'(1);
                        r_state     <= S_RED_B;
                    end
                end
                S_RED_B: begin
                    if (i_rsp.done) begin
                        r_b     <= i_rsp.result;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res   <= '0;
                    r_eq    <= 1'b0;
                    r_state <= S_OUT;
                    case (r_op)
                        OP_ADD: begin
                            if (sum >= mod_e) begin
                                r_res <= Width'(sum - mod_e);
                            end else begin
                                r_res <= sum[Width-1:0];
                            end
                        end
                        OP_SUB: begin
                            if (r_a < r_b) begin
                                r_res <= Width'(sum - {1'b0, r_b} - {1'b0, r_b} + mod_e);
                            end else begin
                                r_res <= r_a - r_b;
                            end
                        end
                        OP_MUL: begin
                            r_req.start <= 1'b1;
                            r_req.x     <= {{Width{1'b0}}, r_a};
                            r_req.y     <= r_b;
                            r_state     <= S_FIN;
                        end
                        OP_DIV: begin
                            if (r_b != '0 && i_mod >= Width'(2)) begin
                                // acc = 1 mod m, exponent m-2
                                r_acc  <= Width'(1);
                                r_base <= r_b;
                                r_exp  <= i_mod - Width'(2);
                                r_state <= S_PMUL;
                            end
                        end
                        OP_EQ: r_eq <= (r_a == r_b);
                        default: ;
                    endcase
                end
                S_PMUL: begin
                    // issue acc*base when low exponent bit is set, else base*base; a*acc once exponent is zero
                    if (!i_rsp.busy && !r_req.start) begin
                        if (r_exp == '0) begin
                            r_req.start <= 1'b1;
                            r_req.x     <= {{Width{1'b0}}, r_a};
                            r_req.y     <= r_acc;
                            r_state     <= S_FIN;
                        end else if (r_exp[0]) begin
                            r_req.start <= 1'b1;
                            r_req.x     <= {{Width{1'b0}}, r_acc};
                            r_req.y     <= r_base;
                            r_state     <= S_PSQ;
                            r_wait      <= 1'b1;
                        end else begin
                            r_req.start <= 1'b1;
                            r_req.x     <= {{Width{1'b0}}, r_base};
                            r_req.y     <= r_base;
                            r_state     <= S_PSQ;
                            r_wait      <= 1'b0;
                        end
                    end
                end
                S_PSQ: begin
                    if (i_rsp.done) begin
                        if (r_wait) begin
                            // product went to acc, now square
                            r_acc       <= i_rsp.result;
                            r_wait      <= 1'b0;
                            r_req.start <= 1'b1;
                            r_req.x     <= {{Width{1'b0}}, r_base};
                            r_req.y     <= r_base;
                        end else begin
                            r_base  <= i_rsp.result;
                            r_exp   <= r_exp >> 1;
                            r_state <= S_PMUL;
                        end
                    end
                end
                S_FIN: begin
                    if (i_rsp.done) begin
                        r_res   <= i_rsp.result;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    if (r_valid && out_ch.ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MAU_ASSERT(a_valid_only_out, out_ch.valid |-> r_state == S_OUT,
        "result beat outside output state")
    `MAU_ASSERT(a_eq_flag_cmp, out_ch.valid && out_ch.equal_flag |-> r_op == OP_EQ,
        "equal flag set for non-compare")
    `MAU_ASSERT(a_no_start_busy, r_req.start |-> !i_rsp.busy,
        "start issued while unit busy")
    `MAU_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> r_state == S_IDLE && !r_valid,
        "not idle after reset")

endmodule

// ===== test/modular_arithmetic_unit_top_test.sv =====
module modular_arithmetic_unit_top_test
    import mau_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [Width-1:0] value;
        logic             eq;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mau_in_if  in_ch();
    mau_out_if out_ch();
    mau_cfg_if cfg_ch();

    modular_arithmetic_unit_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    always #1 i_clk = ~i_clk;

    logic [Width-1:0] cur_modulus;
    t_answer          pending_answers[$];
    int               mismatches = 0;
    int               hold_off_cycles = 0;
    longint unsigned  cycle_count = 0;
    bit               stall_random = 1'b1;

    localparam longint unsigned CycleLimit = 64'd40_000_000;

    function automatic logic [Width-1:0] mulmod(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] m);
        logic [127:0] p;
        p = x * y;
        return Width'(p % m);
    endfunction

    function automatic t_answer predict_answer(logic [2:0] op, logic [Width-1:0] a_in,
                                               logic [Width-1:0] b_in);
        t_answer     ans;
        logic [63:0] m, a, b, s, acc, base, e;
        m = (cur_modulus < 2) ? 64'd1 : 64'(cur_modulus);
        a = 64'(a_in) % m;
        b = 64'(b_in) % m;
        ans = '0;
        case (op)
            OP_ADD: begin
                s = a + b;
                if (s >= m) s = s - m;
                ans.value = Width'(s);
            end
            OP_SUB: ans.value = Width'((a < b) ? (a + m - b) : (a - b));
            OP_MUL: ans.value = mulmod(a, b, m);
            OP_DIV: begin
                if (b != 0 && m >= 2) begin
                    acc = 1 % m;
                    base = b;
                    e = m - 2;
                    while (e != 0) begin
                        if (e[0]) acc = mulmod(acc, base, m);
                        base = mulmod(base, base, m);
                        e = e >> 1;
                    end
                    ans.value = mulmod(a, acc, m);
                end
            end
            OP_EQ: ans.eq = (a == b);
            default: ;
        endcase
        return ans;
    endfunction

    // valid stays high after the beat; gaps and drains drop it
    task automatic send_operation(logic [2:0] op, logic [Width-1:0] a, logic [Width-1:0] b);
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_answers.push_back(predict_answer(op, a, b));
    endtask

    // bursts: gap only sometimes, so back-to-back offers also occur
    task automatic send_random_gap();
        if ($urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [Width-1:0] m);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cur_modulus = m;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [Width-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return cur_modulus;
            3: return cur_modulus - 1;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed_edges();
        logic [2:0] op;
        for (int k = 0; k < 5; k++) begin
            op = 3'(k);
            send_operation(op, '1, '1);
            send_operation(op, 32'd5, '0);
        end
        send_operation(OP_DIV, 32'd7, 32'd3);
        send_operation(OP_SUB, 32'd1, cur_modulus - 1);
        send_operation(OP_EQ, cur_modulus, '0);
        send_operation(3'd5, 32'd9, 32'd9);
        send_operation(3'd6, '1, 32'd1);
        send_operation(3'd7, 32'd3, 32'd3);
        send_operation(OP_MUL, cur_modulus - 1, cur_modulus - 1);
    endtask

    task automatic test_random_ops(int count);
        logic [2:0] op;
        for (int k = 0; k < count; k++) begin
            op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            send_operation(op, pick_operand(), pick_operand());
            send_random_gap();
        end
    endtask

    // long receiver hold-off while items keep coming
    task automatic test_backpressure();
        wait_drained();
        hold_off_cycles = 3000;
        test_random_ops(4);
    endtask

    task automatic test_small_moduli();
        write_modulus(32'd2);
        test_directed_edges();
        write_modulus(32'd0);
        test_random_ops(8);
        write_modulus(32'd1);
        test_random_ops(8);
        write_modulus(32'd3);
        test_random_ops(10);
        write_modulus(32'd251);
        test_random_ops(40);
    endtask

    task automatic test_large_moduli();
        write_modulus(32'hFFFF_FFFB);
        test_random_ops(30);
        write_modulus(32'hFFFF_FFFF);
        test_random_ops(15);
        write_modulus(32'd65521);
        test_random_ops(30);
        write_modulus($urandom() | 32'h1);
        test_random_ops(15);
    endtask

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= '0;
        in_ch.operand_a <= '0;
        in_ch.operand_b <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= '0;
        cur_modulus = ModReset;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_random_ops(90);
        test_backpressure();
        test_small_moduli();
        test_large_moduli();
        write_modulus(ModReset);
        test_random_ops(15);
        wait_drained();
        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // receiver: own stall pattern plus the hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_random <= ~stall_random;
            out_ch.ready <= stall_random ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    initial out_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value %0d eq %0b",
                             out_ch.result_value, out_ch.equal_flag);
            end else begin
                want = pending_answers.pop_front();
                if (want.value !== out_ch.result_value || want.eq !== out_ch.equal_flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b got %0d/%0b", want.value,
                                 want.eq, out_ch.result_value, out_ch.equal_flag);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
